FILE: rtl/pps_pkg.sv
// Types and constants shared by the polygon plane splitter.
package pps_pkg;

    localparam int COORD_W = 32;
    localparam int DIST_W  = 48;
    localparam int CNT_W   = 10;
    localparam int FRAC_W  = 30;

    localparam logic [1:0] KIND_FRONT   = 2'd0;
    localparam logic [1:0] KIND_BACK    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] REG_NORMAL_X = 2'd0;
    localparam logic [1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [1:0] REG_NORMAL_Z = 2'd2;
    localparam logic [1:0] REG_OFFSET   = 2'd3;

    localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               final_vertex;
    } vertex_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic [9:0]         front_total;
        logic [9:0]         back_total;
        logic               front_kept;
        logic               back_kept;
        logic               overflow;
        logic               run_end;
    } result_t;

    // Request to the shared multiply unit.
    typedef struct packed {
        logic               start;
        logic signed [33:0] a;
        logic signed [33:0] b;
    } mul_req_t;

endpackage

FILE: rtl/polygon_plane_splitter.sv
// Top level of the polygon plane splitter with its control sequencer.
//
// Usage: vertices enter on the s_ channel (valid/ready, one transfer per vertex,
// final_vertex marks the last one of a polygon). Results leave on the m_ channel
// as front vertices, back vertices and, after the final vertex, one summary item
// with counts, keep flags and overflow. run_end marks the last result of a vertex.
// Plane registers are to be written on the cfg_ channel only while the block is
// idle; the block itself does not enforce this.
// Timing: one vertex is taken at a time; s_ready is low while it is worked on.
// The distance uses the shared multiplier for three products and one sum.
// Each edge is set up, then its output slots (3 or 4) are visited in turn.
// An edge that crosses the plane first runs the bit-serial divider, then the
// interpolation multiplies. Each result is held in an output register; when
// the receiver stalls the sequencer waits, nothing is dropped.
// Reset (aresetn low, synchronous) closes any open polygon, empties the output
// register and loads the plane x = 0 with normal (1, 0, 0).
module polygon_plane_splitter #(
    parameter int MAX_POINTS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pps_pkg::vertex_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pps_pkg::result_t   m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DMUL  = 4'd1;  // issue x, y, z products
    localparam logic [3:0] ST_DSUM  = 4'd2;  // finish distance
    localparam logic [3:0] ST_EDGE  = 4'd3;  // pick next edge
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_LERP  = 4'd5;
    localparam logic [3:0] ST_EMIT  = 4'd6;
    localparam logic [3:0] ST_SUMM  = 4'd7;

    localparam int CNT_W_L = pps_pkg::CNT_W;

    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [31:0] off_reg;

    logic [3:0] state_reg;
    logic [1:0] step_reg;
    logic       last_reg;
    logic       closing_reg;   // working on the closing edge
    logic       in_poly_reg;
    logic       open_edge_reg; // first vertex had no incoming edge

    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic signed [47:0] cd_reg;
    logic signed [31:0] fx_reg, fy_reg, fz_reg;
    logic signed [47:0] fd_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [47:0] pd_reg;
    logic signed [63:0] acc_reg;

    // current edge A -> B
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic signed [47:0] da, db;

    logic signed [31:0] ix_reg, iy_reg, iz_reg;
    logic [CNT_W_L-1:0] fcnt_reg, bcnt_reg;

    // emission queue: four slots per edge, up to 3 items sent
    logic [1:0] emit_idx_reg;
    logic       cross_reg;

    logic        out_full_reg;
    pps_pkg::result_t out_reg;

    pps_pkg::mul_req_t  mreq;
    logic signed [67:0] mprod;
    logic               div_start, div_done;
    logic [29:0]        tq;
    logic [48:0]        dnum, dden;

    pps_mul u_mul (.aclk(aclk), .req(mreq), .product(mprod));
    pps_div u_div (.aclk(aclk), .aresetn(aresetn), .start(div_start), .num(dnum),
                   .den(dden), .done(div_done), .quot(tq));

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_full_reg;
    assign m_data    = out_reg;

    // The closing edge runs from the current vertex back to the first one.
    always_comb begin
        if (closing_reg) begin
            ax = cx_reg; ay = cy_reg; az = cz_reg; da = cd_reg;
            bx = fx_reg; by = fy_reg; bz = fz_reg; db = fd_reg;
        end else begin
            ax = px_reg; ay = py_reg; az = pz_reg; da = pd_reg;
            bx = cx_reg; by = cy_reg; bz = cz_reg; db = cd_reg;
        end
    end

    logic [47:0] mag_a, mag_b;
    assign mag_a = da[47] ? 48'(-da) : 48'(da);
    assign mag_b = db[47] ? 48'(-db) : 48'(db);
    assign dnum  = {1'b0, mag_a};
    assign dden  = {1'b0, mag_a} + {1'b0, mag_b};

    logic edge_cross;
    assign edge_cross = (!db[47] && db != 0 && da[47]) || (db[47] && !da[47] && da != 0);

    // lerp operand for the coordinate selected by step
    logic signed [32:0] ldiff;
    always_comb begin
        case (step_reg)
            2'd0:    ldiff = 33'(bx) - 33'(ax);
            2'd1:    ldiff = 33'(by) - 33'(ay);
            default: ldiff = 33'(bz) - 33'(az);
        endcase
    end
    logic [32:0] lmag;
    assign lmag = ldiff[32] ? 33'(-ldiff) : 33'(ldiff);

    // lerp result from previous cycle's product
    logic [1:0]         lstep_reg;
    logic               lsign_reg, lpend_reg;
    logic [33:0]        loff;
    logic signed [31:0] lbase, lres;
    assign loff = 34'((mprod[63:0] + 64'd536870912) >> 30);
    always_comb begin
        case (lstep_reg)
            2'd0:    lbase = ax;
            2'd1:    lbase = ay;
            default: lbase = az;
        endcase
    end
    assign lres = lsign_reg ? 32'(lbase - 32'(loff)) : 32'(lbase + 32'(loff));

    // item to emit next
    logic [1:0]         ekind;
    logic signed [31:0] ex, ey, ez;
    logic               elast_here, eskip;
    always_comb begin
        eskip = 1'b0;
        ekind = pps_pkg::KIND_FRONT;
        ex = bx; ey = by; ez = bz;
        case (emit_idx_reg)
            2'd0: begin
                eskip = !cross_reg;
                ex = ix_reg; ey = iy_reg; ez = iz_reg;
            end
            2'd1: begin
                eskip = !cross_reg;
                ekind = pps_pkg::KIND_BACK;
                ex = ix_reg; ey = iy_reg; ez = iz_reg;
            end
            2'd2: begin
                eskip = db[47];
            end
            default: begin
                ekind = pps_pkg::KIND_BACK;
                eskip = !(db[47] || db == 0);
            end
        endcase
        elast_here = (emit_idx_reg == 2'd3) || (emit_idx_reg == 2'd2 && db > 0);
    end

    logic [9:0] max_pts;
    assign max_pts = 10'(MAX_POINTS > 1023 ? 1023 : MAX_POINTS);

    // Next output item and whether it loads the output register this cycle.
    logic             load_out;
    pps_pkg::result_t out_next;
    always_comb begin
        out_next = '0;
        if (state_reg == ST_SUMM) begin
            load_out = !out_full_reg || m_ready;
            out_next.kind        = pps_pkg::KIND_SUMMARY;
            out_next.front_total = fcnt_reg;
            out_next.back_total  = bcnt_reg;
            out_next.front_kept  = fcnt_reg > 10'd2;
            out_next.back_kept   = bcnt_reg > 10'd2;
            out_next.overflow    = (fcnt_reg > max_pts) || (bcnt_reg > max_pts);
            out_next.run_end     = 1'b1;
        end else begin
            load_out = (state_reg == ST_EMIT) && !eskip && (!out_full_reg || m_ready);
            out_next.kind = ekind;
            out_next.ox   = ex;
            out_next.oy   = ey;
            out_next.oz   = ez;
            // the last item of a non-final vertex ends its run
            out_next.run_end = elast_here && !last_reg;
        end
    end

    always_comb begin
        mreq.start = 1'b0;
        mreq.a = '0;
        mreq.b = '0;
        if (state_reg == ST_DMUL) begin
            mreq.start = 1'b1;
            case (step_reg)
                2'd0:    begin mreq.a = 34'(nx_reg); mreq.b = 34'(cx_reg); end
                2'd1:    begin mreq.a = 34'(ny_reg); mreq.b = 34'(cy_reg); end
                default: begin mreq.a = 34'(nz_reg); mreq.b = 34'(cz_reg); end
            endcase
        end else if (state_reg == ST_LERP && step_reg != 2'd3) begin
            mreq.start = 1'b1;
            mreq.a = {1'b0, lmag};
            mreq.b = {4'd0, tq};
        end
    end

    assign div_start = (state_reg == ST_EDGE) && edge_cross;

    logic signed [63:0] dsum;
    assign dsum = acc_reg + 64'(mprod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg <= 16'sd16384; ny_reg <= '0; nz_reg <= '0; off_reg <= '0;
            state_reg <= ST_IDLE;
            in_poly_reg <= 1'b0;
            out_full_reg <= 1'b0;
            fcnt_reg <= '0; bcnt_reg <= '0;
            lpend_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    pps_pkg::REG_NORMAL_X: nx_reg  <= cfg_data[15:0];
                    pps_pkg::REG_NORMAL_Y: ny_reg  <= cfg_data[15:0];
                    pps_pkg::REG_NORMAL_Z: nz_reg  <= cfg_data[15:0];
                    default:               off_reg <= cfg_data;
                endcase
            end
            // hold the result until the receiver takes it
            if (load_out) begin
                out_full_reg <= 1'b1;
                out_reg <= out_next;
            end else if (m_ready) begin
                out_full_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cx_reg <= s_data.vx; cy_reg <= s_data.vy; cz_reg <= s_data.vz;
                        last_reg <= s_data.final_vertex;
                        step_reg <= 2'd0;
                        acc_reg <= '0;
                        state_reg <= ST_DMUL;
                    end
                end
                ST_DMUL: begin
                    // accumulate product of previous step
                    if (step_reg != 2'd0) begin
                        acc_reg <= dsum;
                    end
                    if (step_reg == 2'd2) begin
                        state_reg <= ST_DSUM;
                    end
                    step_reg <= step_reg + 2'd1;
                end
                ST_DSUM: begin
                    // floor by 2^14, then add the plane constant
                    cd_reg <= 48'(dsum >>> 14) + 48'(off_reg);
                    closing_reg <= 1'b0;
                    open_edge_reg <= !in_poly_reg;
                    if (!in_poly_reg) begin
                        fx_reg <= cx_reg; fy_reg <= cy_reg; fz_reg <= cz_reg;
                        fd_reg <= 48'(dsum >>> 14) + 48'(off_reg);
                        fcnt_reg <= '0; bcnt_reg <= '0;
                        in_poly_reg <= 1'b1;
                    end
                    state_reg <= ST_EDGE;
                end
                ST_EDGE: begin
                    emit_idx_reg <= 2'd0;
                    cross_reg <= edge_cross;
                    if (open_edge_reg && !closing_reg) begin
                        // first vertex: no incoming edge
                        if (last_reg) begin
                            closing_reg <= 1'b1;
                        end else begin
                            px_reg <= cx_reg; py_reg <= cy_reg; pz_reg <= cz_reg;
                            pd_reg <= cd_reg;
                            state_reg <= ST_IDLE;
                        end
                    end else if (edge_cross) begin
                        state_reg <= ST_DIV;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        step_reg <= 2'd0;
                        state_reg <= ST_LERP;
                    end
                end
                ST_LERP: begin
                    lpend_reg <= (step_reg != 2'd3);
                    lstep_reg <= step_reg;
                    lsign_reg <= ldiff[32];
                    if (lpend_reg) begin
                        case (lstep_reg)
                            2'd0:    ix_reg <= lres;
                            2'd1:    iy_reg <= lres;
                            default: iz_reg <= lres;
                        endcase
                    end
                    if (step_reg == 2'd3) begin
                        state_reg <= ST_EMIT;
                    end
                    step_reg <= step_reg + 2'd1;
                end
                ST_EMIT: begin
                    // advance past a skipped slot or one that was just sent
                    if (eskip || load_out) begin
                        emit_idx_reg <= emit_idx_reg + 2'd1;
                    end
                    if (load_out) begin
                        if (ekind == pps_pkg::KIND_FRONT) begin
                            if (fcnt_reg != pps_pkg::COUNT_MAX) fcnt_reg <= fcnt_reg + 10'd1;
                        end else begin
                            if (bcnt_reg != pps_pkg::COUNT_MAX) bcnt_reg <= bcnt_reg + 10'd1;
                        end
                    end
                    if ((eskip || load_out) && elast_here) begin
                        if (!last_reg) begin
                            px_reg <= cx_reg; py_reg <= cy_reg; pz_reg <= cz_reg;
                            pd_reg <= cd_reg;
                            state_reg <= ST_IDLE;
                        end else if (!closing_reg) begin
                            closing_reg <= 1'b1;
                            state_reg <= ST_EDGE;
                        end else begin
                            state_reg <= ST_SUMM;
                        end
                    end
                end
                ST_SUMM: begin
                    if (load_out) begin
                        fcnt_reg <= '0; bcnt_reg <= '0;
                        in_poly_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/pps_mul.sv
// Shared registered signed multiplier, one product per cycle.
module pps_mul (
    input  logic               aclk,
    input  pps_pkg::mul_req_t  req,
    output logic signed [67:0] product
);
    always_ff @(posedge aclk) begin
        if (req.start) begin
            product <= req.a * req.b;
        end
    end
endmodule

FILE: rtl/pps_div.sv
// Restoring divider: one quotient bit a cycle, gives floor(num * 2^30 / den).
module pps_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [48:0] num,
    input  logic [48:0] den,
    output logic        done,
    output logic [29:0] quot
);
    logic [49:0] rem_reg;
    logic [48:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [49:0] shifted;

    assign shifted = {rem_reg[48:0], 1'b0};
    assign done    = busy_reg && (cnt_reg == 5'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd30;
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot     <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 5'd1;
                if (shifted >= {1'b0, den_reg}) begin
                    rem_reg <= shifted - {1'b0, den_reg};
                    quot    <= {quot[28:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quot    <= {quot[28:0], 1'b0};
                end
            end
        end
    end
endmodule

FILE: rtl/pps_checker.sv
// Port-level checker for the polygon plane splitter, bound to the top level.
module pps_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input pps_pkg::result_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_summary_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == pps_pkg::KIND_SUMMARY |-> m_data.run_end)
        else $error("summary without run_end");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.kind != 2'd3)
        else $error("bad result kind");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted two vertices back to back");
endmodule

bind polygon_plane_splitter pps_checker u_pps_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
